// ===== sv/pta_pkg.sv =====
`default_nettype none

package pta_pkg;

   // Default sizes handed to the top level.
   localparam int unsigned STORE_DEPTH_DEF = 1024;
   localparam int unsigned COORD_BITS_DEF  = 32;

   // Triangle queue between the assembly stage and the result port.
   localparam int unsigned TRI_FIFO_DEPTH = 4;

   // Command codes.
   localparam logic [1:0] CMD_STORE  = 2'd0;
   localparam logic [1:0] CMD_START  = 2'd1;
   localparam logic [1:0] CMD_SUBMIT = 2'd2;

   // Primitive modes.
   localparam logic [2:0] MODE_TRIS    = 3'd0;
   localparam logic [2:0] MODE_STRIP   = 3'd1;
   localparam logic [2:0] MODE_FAN     = 3'd2;
   localparam logic [2:0] MODE_QUADS   = 3'd3;
   localparam logic [2:0] MODE_QSTRIP  = 3'd4;
   localparam logic [2:0] MODE_POLYGON = 3'd5;

   // Fill levels of the assembly buffer.
   localparam logic [1:0] PEND_NONE  = 2'd0;
   localparam logic [1:0] PEND_TWO   = 2'd2;
   localparam logic [1:0] PEND_THREE = 2'd3;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [2:0]         prim_mode;
      logic [9:0]         vert_index;
      logic signed [31:0] in_x;
      logic signed [31:0] in_y;
      logic signed [31:0] in_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] a_x;
      logic signed [31:0] a_y;
      logic signed [31:0] a_z;
      logic signed [31:0] b_x;
      logic signed [31:0] b_y;
      logic signed [31:0] b_z;
      logic signed [31:0] c_x;
      logic signed [31:0] c_y;
      logic signed [31:0] c_z;
      logic               last_of_run;
   } rsp_type;

   typedef struct packed {
      logic lead;
      logic trail;
   } push_type;

   typedef struct packed {
      logic not_empty;
      logic room_two;
   } fifo_status_type;

   // Reduces a vertex index into the store range by conditional subtraction
   // of shifted copies of the depth, largest first.
   function automatic logic [9:0] wrap_index(input logic [9:0] idx,
                                             input int unsigned depth);
      logic [9:0]  r;
      int unsigned step;
      r = idx;
      for (int k = 8; k >= 0; k--) begin
         step = depth << k;
         if (step <= 32'd1023 && 32'(r) >= step) begin
            r = r - 10'(step);
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== sv/primitive_to_triangle_assembler.sv =====
`default_nettype none

// Channel   Ports                            Word
// -------   ------------------------------   ---------------------------------------
// request   req_valid, req_stall, req_data   store, start or submit command
// response  rsp_valid, rsp_stall, rsp_data   one assembled triangle, three corners
//
// One request word is accepted per clock while req_stall is low. A store writes the vertex
// memory at once; a submit reads it, and starts and submits resolve in the assembly stage.
// Results pass through a four-entry triangle queue; req_stall rises only while the
// queue has fewer than two free entries and a word waits in the assembly stage.
// Reset (synchronous) clears mode, buffer count and queue; the vertex memory is
// not cleared, so no clearing pass is needed and requests are taken right away.

module primitive_to_triangle_assembler
   import pta_pkg::*;
#(
   parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF,
   parameter int unsigned COORD_BITS  = COORD_BITS_DEF
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int unsigned ADDR_BITS = $clog2(STORE_DEPTH);

   // A vertex is x, y and z, each kept at COORD_BITS.
   typedef logic [2:0][COORD_BITS-1:0] vert_type;

   function automatic logic signed [31:0] widen(input logic [COORD_BITS-1:0] w);
      return 32'(signed'(w));
   endfunction

   function automatic rsp_type mk_tri(input vert_type a, input vert_type b,
                                      input vert_type c, input logic last);
      rsp_type t;
      t.a_x         = widen(a[0]);
      t.a_y         = widen(a[1]);
      t.a_z         = widen(a[2]);
      t.b_x         = widen(b[0]);
      t.b_y         = widen(b[1]);
      t.b_z         = widen(b[2]);
      t.c_x         = widen(c[0]);
      t.c_y         = widen(c[1]);
      t.c_z         = widen(c[2]);
      t.last_of_run = last;
      return t;
   endfunction

   // Request acceptance and vertex memory access.
   logic                 req_accept;
   logic [ADDR_BITS-1:0] addr;
   vert_type             wr_vert;
   vert_type             vertex_mem [STORE_DEPTH];
   vert_type             rd_data_ff;

   // Assembly stage.
   logic                 s1_valid_ff, s1_valid_in;
   logic [1:0]           s1_cmd_ff;
   logic [2:0]           s1_mode_ff;
   logic                 s1_go;
   logic [2:0]           mode_ff, mode_in;
   logic [1:0]           cnt_ff, cnt_in;
   vert_type             pend_ff [3];
   vert_type             pend_in [3];
   logic                 buffer_new;
   push_type             push;
   rsp_type              tri_lead, tri_trail;
   fifo_status_type      fifo_status;

   // The assembly stage is always free unless the queue is nearly full.
   assign req_stall  = s1_valid_ff && !fifo_status.room_two;
   assign req_accept = req_valid && !req_stall;
   assign s1_go      = s1_valid_ff && fifo_status.room_two;

   assign addr       = ADDR_BITS'(wrap_index(req_data.vert_index, STORE_DEPTH));
   assign wr_vert[0] = req_data.in_x[COORD_BITS-1:0];
   assign wr_vert[1] = req_data.in_y[COORD_BITS-1:0];
   assign wr_vert[2] = req_data.in_z[COORD_BITS-1:0];

   // Stores and reads follow request order, so a read always sees earlier stores.
   always_ff @(posedge clock) begin
      if (req_accept && req_data.cmd == CMD_STORE) begin
         vertex_mem[addr] <= wr_vert;
      end
      if (req_accept && req_data.cmd == CMD_SUBMIT) begin
         rd_data_ff <= vertex_mem[addr];
      end
   end

   assign s1_valid_in = req_accept || (s1_valid_ff && !s1_go);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         mode_ff     <= MODE_TRIS;
         cnt_ff      <= PEND_NONE;
      end else begin
         s1_valid_ff <= s1_valid_in;
         mode_ff     <= mode_in;
         cnt_ff      <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_cmd_ff  <= req_data.cmd;
         s1_mode_ff <= req_data.prim_mode;
      end
      for (int i = 0; i < 3; i++) begin
         pend_ff[i] <= pend_in[i];
      end
   end

   // Primitive rules. The new vertex is the registered memory read.
   always_comb begin
      mode_in    = mode_ff;
      cnt_in     = cnt_ff;
      for (int i = 0; i < 3; i++) begin
         pend_in[i] = pend_ff[i];
      end
      buffer_new = 1'b0;
      push       = '0;
      tri_lead   = mk_tri(pend_ff[0], pend_ff[1], rd_data_ff, 1'b1);
      tri_trail  = mk_tri(pend_ff[0], pend_ff[2], rd_data_ff, 1'b1);

      if (s1_go && s1_cmd_ff == CMD_START) begin
         mode_in = s1_mode_ff;
         cnt_in  = PEND_NONE;
      end else if (s1_go && s1_cmd_ff == CMD_SUBMIT) begin
         unique case (mode_ff)
            MODE_TRIS: begin
               if (cnt_ff == PEND_TWO) begin
                  push.lead = 1'b1;
                  cnt_in    = PEND_NONE;
               end else begin
                  buffer_new = 1'b1;
               end
            end
            MODE_STRIP: begin
               if (cnt_ff == PEND_TWO) begin
                  push.lead  = 1'b1;
                  pend_in[2] = rd_data_ff;
                  cnt_in     = PEND_THREE;
               end else if (cnt_ff == PEND_THREE) begin
                  // Odd triangle of the strip keeps the winding.
                  push.lead  = 1'b1;
                  tri_lead   = mk_tri(pend_ff[2], pend_ff[1], rd_data_ff, 1'b1);
                  pend_in[0] = pend_ff[2];
                  pend_in[1] = rd_data_ff;
                  cnt_in     = PEND_TWO;
               end else begin
                  buffer_new = 1'b1;
               end
            end
            MODE_FAN, MODE_POLYGON: begin
               if (cnt_ff >= PEND_TWO) begin
                  push.lead  = 1'b1;
                  pend_in[1] = rd_data_ff;
               end else begin
                  buffer_new = 1'b1;
               end
            end
            MODE_QUADS: begin
               if (cnt_ff == PEND_THREE) begin
                  push.lead  = 1'b1;
                  push.trail = 1'b1;
                  tri_lead   = mk_tri(pend_ff[0], pend_ff[1], pend_ff[2], 1'b0);
                  cnt_in     = PEND_NONE;
               end else begin
                  buffer_new = 1'b1;
               end
            end
            MODE_QSTRIP: begin
               if (cnt_ff == PEND_THREE) begin
                  push.lead  = 1'b1;
                  push.trail = 1'b1;
                  tri_lead   = mk_tri(pend_ff[0], pend_ff[1], pend_ff[2], 1'b0);
                  tri_trail  = mk_tri(pend_ff[2], pend_ff[1], rd_data_ff, 1'b1);
                  pend_in[0] = pend_ff[2];
                  pend_in[1] = rd_data_ff;
                  cnt_in     = PEND_TWO;
               end else begin
                  buffer_new = 1'b1;
               end
            end
            default: begin
               // Unnamed modes 6 and 7: the submit is dropped.
            end
         endcase
      end

      if (buffer_new) begin
         for (int i = 0; i < 3; i++) begin
            if (cnt_ff == 2'(i)) begin
               pend_in[i] = rd_data_ff;
            end
         end
         cnt_in = cnt_ff + 2'd1;
      end
   end

   pta_tri_fifo u_tri_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .tri_lead  (tri_lead),
      .tri_trail (tri_trail),
      .pop       (rsp_valid && !rsp_stall),
      .head      (rsp_data),
      .status    (fifo_status)
   );

   assign rsp_valid = fifo_status.not_empty;

endmodule

`default_nettype wire

// ===== sv/pta_tri_fifo.sv =====
`default_nettype none

module pta_tri_fifo
   import pta_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  push_type        push,
   input  rsp_type         tri_lead,
   input  rsp_type         tri_trail,
   input  logic            pop,
   output rsp_type         head,
   output fifo_status_type status
);

   localparam int unsigned PTR_BITS = $clog2(TRI_FIFO_DEPTH);

   rsp_type             slot_ff [TRI_FIFO_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]   count_ff, count_in;
   logic [PTR_BITS:0]   n_push;
   logic [PTR_BITS-1:0] wr_next;

   // The trailing triangle is only ever pushed together with the leading one.
   assign n_push    = (PTR_BITS+1)'(push.lead) + (PTR_BITS+1)'(push.trail);
   assign wr_next   = wr_ptr_ff + PTR_BITS'(1);
   assign wr_ptr_in = wr_ptr_ff + PTR_BITS'(n_push);
   assign rd_ptr_in = rd_ptr_ff + PTR_BITS'(pop);
   assign count_in  = count_ff + n_push - (PTR_BITS+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.lead) begin
         slot_ff[wr_ptr_ff] <= tri_lead;
      end
      if (push.trail) begin
         slot_ff[wr_next] <= tri_trail;
      end
   end

   assign head             = slot_ff[rd_ptr_ff];
   assign status.not_empty = (count_ff != '0);
   assign status.room_two  = (count_ff <= (PTR_BITS+1)'(TRI_FIFO_DEPTH - 2));

endmodule

`default_nettype wire

// ===== sv/pta_checker.sv =====
`default_nettype none

module pta_checker
   import pta_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // The queue starts out empty.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // The first triangle of a pair is always followed by its partner.
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last_of_run |=> rsp_valid)
      else $error("second triangle of a pair missing");

   // Requests are held back only while results are queued.
   a_stall_needs_backlog: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with an empty result queue");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed");

endmodule

bind primitive_to_triangle_assembler pta_checker u_pta_checker (.*);

`default_nettype wire

// ===== sim/assembly_checker.sv =====
`timescale 1ns / 1ps

module assembly_checker
   import pta_pkg::*;
#(
   parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF,
   parameter int unsigned COORD_BITS  = COORD_BITS_DEF
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      mismatch_count,
   output int      pending_tris
);

   localparam int NUM_COORDS = 9;

   // One vertex in the same x, y, z order as the corners of a triangle word.
   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } corner_type;

   corner_type vertex_mem [STORE_DEPTH];
   corner_type held [3];
   logic [1:0] held_count;
   logic [2:0] active_mode;
   rsp_type    tri_queue [$];
   rsp_type    want_tri;
   string      bad_fields;
   string      coord_names [NUM_COORDS] = '{"a_x", "a_y", "a_z", "b_x", "b_y", "b_z",
                                            "c_x", "c_y", "c_z"};

   function automatic logic [31:0] fit_coord(input logic [31:0] raw);
      logic [31:0] shifted;
      shifted = raw << (32 - COORD_BITS);
      return $signed(shifted) >>> (32 - COORD_BITS);
   endfunction

   function automatic void push_tri(input corner_type a, input corner_type b,
                                    input corner_type c, input logic last);
      tri_queue.insert(tri_queue.size(), {a, b, c, last});
   endfunction

   task automatic assemble(input req_type w);
      corner_type  v;
      int unsigned slot;
      slot = w.vert_index % STORE_DEPTH;
      case (w.cmd)
         CMD_STORE: begin
            vertex_mem[slot] = {fit_coord(w.in_x), fit_coord(w.in_y), fit_coord(w.in_z)};
         end
         CMD_START: begin
            active_mode = w.prim_mode;
            held_count  = PEND_NONE;
         end
         CMD_SUBMIT: begin
            // Submits under an unsupported mode leave everything untouched.
            if (active_mode <= MODE_POLYGON) begin
               v = vertex_mem[slot];
               case (active_mode)
                  MODE_TRIS: begin
                     if (held_count == PEND_TWO) begin
                        push_tri(held[0], held[1], v, 1'b1);
                        held_count = PEND_NONE;
                     end else begin
                        held[held_count] = v;
                        held_count++;
                     end
                  end
                  MODE_STRIP: begin
                     if (held_count == PEND_TWO) begin
                        push_tri(held[0], held[1], v, 1'b1);
                        held[2]    = v;
                        held_count = PEND_THREE;
                     end else if (held_count == PEND_THREE) begin
                        push_tri(held[2], held[1], v, 1'b1);
                        held[0]    = held[2];
                        held[1]    = v;
                        held_count = PEND_TWO;
                     end else begin
                        held[held_count] = v;
                        held_count++;
                     end
                  end
                  MODE_FAN, MODE_POLYGON: begin
                     if (held_count >= PEND_TWO) begin
                        push_tri(held[0], held[1], v, 1'b1);
                        held[1] = v;
                     end else begin
                        held[held_count] = v;
                        held_count++;
                     end
                  end
                  MODE_QUADS: begin
                     if (held_count == PEND_THREE) begin
                        push_tri(held[0], held[1], held[2], 1'b0);
                        push_tri(held[0], held[2], v, 1'b1);
                        held_count = PEND_NONE;
                     end else begin
                        held[held_count] = v;
                        held_count++;
                     end
                  end
                  default: begin
                     if (held_count == PEND_THREE) begin
                        push_tri(held[0], held[1], held[2], 1'b0);
                        push_tri(held[2], held[1], v, 1'b1);
                        held[0]    = held[2];
                        held[1]    = v;
                        held_count = PEND_TWO;
                     end else begin
                        held[held_count] = v;
                        held_count++;
                     end
                  end
               endcase
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         held_count     = PEND_NONE;
         active_mode    = MODE_TRIS;
         tri_queue.delete();
         mismatch_count = 0;
         pending_tris   = 0;
      end else begin
         if (req_valid && !req_stall) begin
            assemble(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            if (tri_queue.size() == 0) begin
               if (mismatch_count < 10) begin
                  $display("assembly_checker: unexpected triangle %h", rsp_data);
               end
               mismatch_count++;
            end else begin
               want_tri   = tri_queue.pop_front();
               bad_fields = "";
               for (int f = 0; f < NUM_COORDS; f++) begin
                  if (rsp_data[288 - 32 * f -: 32] !== want_tri[288 - 32 * f -: 32]) begin
                     bad_fields = {bad_fields, " ", coord_names[f]};
                  end
               end
               if (rsp_data.last_of_run !== want_tri.last_of_run) begin
                  bad_fields = {bad_fields, " last_of_run"};
               end
               if (bad_fields != "") begin
                  if (mismatch_count < 10) begin
                     $display("assembly_checker: mismatch in%s: expected %h got %h",
                              bad_fields, want_tri, rsp_data);
                  end
                  mismatch_count++;
               end
            end
         end
         pending_tris = tri_queue.size();
      end
   end

endmodule

// ===== sim/primitive_to_triangle_assembler_tb.sv =====
`timescale 1ns / 1ps

module primitive_to_triangle_assembler_tb;
   import pta_pkg::*;

   localparam int unsigned DEPTH        = STORE_DEPTH_DEF;
   localparam int          RANDOM_WORDS = 400;
   localparam int          HOLD_CYCLES  = 120;

   // Codes that the package leaves unnamed: the unused command and the two
   // mode values the block records but does not assemble.
   localparam logic [1:0] CMD_UNUSED  = 2'd3;
   localparam logic [2:0] MODE_RSVD6  = 3'd6;
   localparam logic [2:0] MODE_RSVD7  = 3'd7;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   int      mismatch_count;
   int      pending_tris;

   // Shared between the two driving processes: random gaps on or off, and a
   // one-shot request for the long receiver hold-off.
   bit          gaps_on  = 1'b1;
   bit          hold_now = 1'b0;
   bit          stored_flag [DEPTH];
   int unsigned stored_list [$];
   int          words_sent;

   always #1 clock = ~clock;

   primitive_to_triangle_assembler u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assembly_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .pending_tris   (pending_tris)
   );

   // Offers one word and returns at the edge where it is taken. A random gap
   // may come first; valid then stays high until acceptance, and the payload
   // is held steady while the block stalls.
   task automatic send_word(input req_type w);
      while (gaps_on && $urandom_range(99) < 21) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      if (w.cmd != CMD_UNUSED) begin
         words_sent++;
      end
   endtask

   // Coordinates lean on the extremes of the signed Q16.16 range.
   function automatic logic [31:0] pick_coord();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Submits only ever name entries that were written before, so the store
   // is never read where it holds nothing defined.
   function automatic int unsigned pick_stored();
      return stored_list[$urandom_range(stored_list.size() - 1)];
   endfunction

   task automatic store_vertex(input int unsigned idx, input logic [31:0] x,
                               input logic [31:0] y, input logic [31:0] z);
      req_type w;
      w.cmd        = CMD_STORE;
      w.prim_mode  = 3'($urandom_range(7));
      w.vert_index = 10'(idx);
      w.in_x       = x;
      w.in_y       = y;
      w.in_z       = z;
      send_word(w);
      if (!stored_flag[idx]) begin
         stored_flag[idx] = 1'b1;
         stored_list.insert(stored_list.size(), idx);
      end
   endtask

   // Fields that a command does not use carry random bits, so every bit of
   // every field is exercised in both states.
   task automatic start_prim(input logic [2:0] mode);
      req_type w;
      w.cmd        = CMD_START;
      w.prim_mode  = mode;
      w.vert_index = 10'($urandom);
      w.in_x       = $urandom;
      w.in_y       = $urandom;
      w.in_z       = $urandom;
      send_word(w);
   endtask

   task automatic submit_vertex(input int unsigned idx);
      req_type w;
      w.cmd        = CMD_SUBMIT;
      w.prim_mode  = 3'($urandom_range(7));
      w.vert_index = 10'(idx);
      w.in_x       = $urandom;
      w.in_y       = $urandom;
      w.in_z       = $urandom;
      send_word(w);
   endtask

   task automatic send_unused();
      req_type w;
      w.cmd        = CMD_UNUSED;
      w.prim_mode  = 3'($urandom_range(7));
      w.vert_index = 10'($urandom);
      w.in_x       = $urandom;
      w.in_y       = $urandom;
      w.in_z       = $urandom;
      send_word(w);
   endtask

   // Receiver side. Once per run it holds stall high for a long stretch while
   // the sender keeps pushing a fan, so the triangle queue fills and the
   // block has to stall its request side.
   initial begin : response_side
      forever begin
         @(posedge clock);
         if (hold_now) begin
            rsp_stall <= 1'b1;
            for (int n = 0; n < HOLD_CYCLES; n++) begin
               @(posedge clock);
            end
            hold_now = 1'b0;
         end
         rsp_stall <= gaps_on && ($urandom_range(99) < 21);
      end
   end

   initial begin : request_side
      int unsigned slot;
      int          run_len;
      logic [2:0]  run_mode;
      bit          hold_started;
      hold_started = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Corner values at both ends of the store, then a
      // triangle before any start (reset mode), one run in each mode that
      // emits at a distinct step, an unsupported mode and an unused command.
      store_vertex(0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
      store_vertex(DEPTH - 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
      store_vertex(512, pick_coord(), pick_coord(), pick_coord());
      submit_vertex(0);
      submit_vertex(DEPTH - 1);
      submit_vertex(512);

      // Strip: the third and fourth vertex each close a triangle, with the
      // winding flipped on the fourth.
      start_prim(MODE_STRIP);
      submit_vertex(0);
      submit_vertex(DEPTH - 1);
      submit_vertex(512);
      submit_vertex(0);

      // Quads and quad strip: two triangles on the fourth vertex.
      start_prim(MODE_QUADS);
      submit_vertex(0);
      submit_vertex(DEPTH - 1);
      submit_vertex(512);
      submit_vertex(DEPTH - 1);
      start_prim(MODE_QSTRIP);
      submit_vertex(512);
      submit_vertex(0);
      submit_vertex(DEPTH - 1);
      submit_vertex(0);

      // Unsupported mode swallows submits; the unused command does nothing.
      start_prim(MODE_RSVD6);
      submit_vertex(0);
      send_unused();

      // Random part. Mostly well-formed runs (start, then a burst of
      // submits) with random content, mixed with stores, stray submits that
      // continue the current run, unsupported modes and unused words.
      words_sent = 0;
      while (words_sent < RANDOM_WORDS) begin
         // A stretch in the middle runs with no gaps on either side.
         gaps_on = !(words_sent >= 150 && words_sent < 250);
         if (!hold_started && words_sent >= 300) begin
            hold_started = 1'b1;
            hold_now     = 1'b1;
            start_prim(MODE_FAN);
            repeat (12) submit_vertex(pick_stored());
         end
         case ($urandom_range(19))
            0, 1, 2: begin
               slot = ($urandom_range(9) == 0) ? (($urandom_range(1) == 0) ? 0 : DEPTH - 1)
                                               : $urandom_range(DEPTH - 1);
               store_vertex(slot, pick_coord(), pick_coord(), pick_coord());
            end
            3: begin
               send_unused();
            end
            4: begin
               submit_vertex(pick_stored());
            end
            default: begin
               run_mode = ($urandom_range(12) == 0)
                          ? (($urandom_range(1) == 0) ? MODE_RSVD6 : MODE_RSVD7)
                          : 3'($urandom_range(5));
               run_len  = $urandom_range(12, 1);
               start_prim(run_mode);
               repeat (run_len) submit_vertex(pick_stored());
            end
         endcase
      end
      req_valid <= 1'b0;
      gaps_on = 1'b0;

      // Drain: let the checker absorb the last accepted word, wait for every
      // predicted triangle, then a short quiet spell to catch extra words.
      @(posedge clock);
      while (pending_tris != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_tris == 0) begin
         $display("primitive_to_triangle_assembler_tb: clean");
      end else begin
         $display("primitive_to_triangle_assembler_tb: errors");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run of this stimulus.
   initial begin : watchdog
      #400_000;
      $display("primitive_to_triangle_assembler_tb: errors");
      $finish;
   end

endmodule
